// File: rtl/bvra_pkg.sv
// ============================================================================
// bvra_pkg: shared constants and types of the vector range allocator
// Sizes, opcodes and the command/status bundles between control and datapath.
// ============================================================================
package bvra_pkg;

  localparam int NUM_CPUS    = 8;
  localparam int NUM_VECTORS = 256;

  localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int VEC_W     = $clog2(NUM_VECTORS);
  localparam int CNT_W     = $clog2(NUM_VECTORS + 1);
  localparam int CPU_OUT_W = 3;
  localparam int FV_W      = 8;
  localparam int BASE_W    = 8;
  localparam int REQ_W     = 9;
  localparam int SUM_W     = CNT_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request word
    logic scan_step;   // compare one CPU free count
    logic pick;        // point row at best CPU, arm search
    logic search_step; // test one map bit
    logic alloc;       // mark run, update counts
    logic free_run;    // clear run, update counts
    logic res_deny;
    logic res_alloc;
    logic res_free;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_free;
    logic sel_ok;
    logic scan_last;
    logic fit_fail;
    logic found;
    logic search_last;
  } status_t;

endpackage

// File: rtl/bvra_ctrl.sv
// ============================================================================
// bvra_ctrl: request sequencer
// Steps through CPU scan, first-fit search and commit; drives busy and done.
// ============================================================================
module bvra_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bvra_pkg::status_t stat,
  output bvra_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PICK   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_ALLOC  = 3'd4;
  localparam logic [2:0] S_FREE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       done_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.op_free) begin
          state_next = S_FREE;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.scan_last) state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        if (stat.fit_fail) begin
          cmd.res_deny = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.found) begin
          state_next = S_ALLOC;
        end else if (stat.search_last) begin
          cmd.res_deny = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ALLOC: begin
        cmd.alloc     = 1'b1;
        cmd.res_alloc = 1'b1;
        state_next    = S_IDLE;
      end
      S_FREE: begin
        if (stat.sel_ok) begin
          cmd.free_run = 1'b1;
          cmd.res_free = 1'b1;
        end else begin
          cmd.res_deny = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign done_next = cmd.res_deny | cmd.res_alloc | cmd.res_free;
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

// File: rtl/bvra_dp.sv
// ============================================================================
// bvra_dp: allocator datapath
// Per-CPU used maps and counts, request registers, scan/search state, result.
// ============================================================================
module bvra_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  bvra_pkg::cmd_t                   cmd,
  output bvra_pkg::status_t                stat,
  input  logic                             opcode,
  input  logic [bvra_pkg::REQ_W-1:0]       count,
  input  logic [2:0]                       cpu_select,
  input  logic [bvra_pkg::BASE_W-1:0]      base_vector,
  output logic                             ok,
  output logic [bvra_pkg::CPU_OUT_W-1:0]   chosen_cpu,
  output logic [bvra_pkg::FV_W-1:0]        first_vector
);

  // bit k set when lo <= k < hi
  function automatic logic [bvra_pkg::NUM_VECTORS-1:0] run_mask(
    input logic [bvra_pkg::SUM_W-1:0] lo,
    input logic [bvra_pkg::SUM_W-1:0] hi
  );
    logic [bvra_pkg::NUM_VECTORS-1:0] m;
    for (int k = 0; k < bvra_pkg::NUM_VECTORS; k++) begin
      m[k] = (bvra_pkg::SUM_W'(k) >= lo) && (bvra_pkg::SUM_W'(k) < hi);
    end
    return m;
  endfunction

  localparam logic [bvra_pkg::SUM_W-1:0] NV_S = bvra_pkg::SUM_W'(bvra_pkg::NUM_VECTORS);

  // state arrays
  logic [bvra_pkg::NUM_VECTORS-1:0] used_map   [bvra_pkg::NUM_CPUS];
  logic [bvra_pkg::CNT_W-1:0]       free_count [bvra_pkg::NUM_CPUS];
  logic [bvra_pkg::CNT_W-1:0]       use_count  [bvra_pkg::NUM_CPUS];

  // request and working registers
  logic                         op_q;
  logic [bvra_pkg::REQ_W-1:0]   cnt_q;
  logic [2:0]                   sel_q;
  logic [bvra_pkg::BASE_W-1:0]  base_q;
  logic [bvra_pkg::CPU_W-1:0]   sel_idx;
  logic [bvra_pkg::CPU_W-1:0]   best_cpu;
  logic [bvra_pkg::CNT_W-1:0]   best_free;
  logic [bvra_pkg::VEC_W-1:0]   vec_idx;
  logic [bvra_pkg::CNT_W-1:0]   run;
  logic [bvra_pkg::VEC_W-1:0]   start_q;

  logic [bvra_pkg::NUM_VECTORS-1:0] row;
  logic [bvra_pkg::CNT_W-1:0]       free_cur;
  logic [bvra_pkg::CNT_W-1:0]       use_cur;
  logic                             map_bit;
  logic [bvra_pkg::CNT_W-1:0]       run_inc;
  logic                             hit;

  logic [bvra_pkg::SUM_W-1:0]       a_lo, a_hi, f_lo, f_hi;
  logic [bvra_pkg::SUM_W-1:0]       use_sum, f_n, f_sum;
  logic [bvra_pkg::CNT_W-1:0]       use_alloc, free_rel, use_rel;

  assign row      = used_map[sel_idx];
  assign free_cur = free_count[sel_idx];
  assign use_cur  = use_count[sel_idx];
  assign map_bit  = row[vec_idx];
  assign run_inc  = run + bvra_pkg::CNT_W'(1);
  assign hit      = !map_bit && (bvra_pkg::SUM_W'(run_inc) == bvra_pkg::SUM_W'(cnt_q));

  // allocate: saturating use count
  assign a_lo      = bvra_pkg::SUM_W'(start_q);
  assign a_hi      = bvra_pkg::SUM_W'(start_q) + bvra_pkg::SUM_W'(cnt_q);
  assign use_sum   = bvra_pkg::SUM_W'(use_cur) + bvra_pkg::SUM_W'(cnt_q);
  assign use_alloc = (use_sum > NV_S) ? bvra_pkg::CNT_W'(bvra_pkg::NUM_VECTORS)
                                      : use_sum[bvra_pkg::CNT_W-1:0];

  // free: vectors past the map are skipped
  assign f_lo     = bvra_pkg::SUM_W'(base_q);
  assign f_hi     = bvra_pkg::SUM_W'(base_q) + bvra_pkg::SUM_W'(cnt_q);
  assign f_n      = (f_hi > NV_S) ? (NV_S - bvra_pkg::SUM_W'(base_q))
                                  : bvra_pkg::SUM_W'(cnt_q);
  assign f_sum    = bvra_pkg::SUM_W'(free_cur) + f_n;
  assign free_rel = (f_sum > NV_S) ? bvra_pkg::CNT_W'(bvra_pkg::NUM_VECTORS)
                                   : f_sum[bvra_pkg::CNT_W-1:0];
  assign use_rel  = (bvra_pkg::SUM_W'(use_cur) > f_n)
                    ? (use_cur - f_n[bvra_pkg::CNT_W-1:0]) : '0;

  always_comb begin
    stat.op_free     = (op_q == bvra_pkg::OP_FREE);
    stat.sel_ok      = (int'(sel_q) < bvra_pkg::NUM_CPUS);
    stat.scan_last   = (sel_idx == bvra_pkg::CPU_W'(bvra_pkg::NUM_CPUS - 1));
    stat.fit_fail    = (cnt_q == '0) ||
                       (bvra_pkg::SUM_W'(best_free) < bvra_pkg::SUM_W'(cnt_q));
    stat.found       = hit;
    stat.search_last = (vec_idx == bvra_pkg::VEC_W'(bvra_pkg::NUM_VECTORS - 1));
  end

  // maps and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < bvra_pkg::NUM_CPUS; c++) begin
        used_map[c]   <= '0;
        free_count[c] <= bvra_pkg::CNT_W'(bvra_pkg::NUM_VECTORS);
        use_count[c]  <= '0;
      end
    end else begin
      if (cmd.alloc) begin
        used_map[sel_idx]   <= row | run_mask(a_lo, a_hi);
        free_count[sel_idx] <= free_cur - cnt_q;
        use_count[sel_idx]  <= use_alloc;
      end
      if (cmd.free_run) begin
        used_map[sel_idx]   <= row & ~run_mask(f_lo, f_hi);
        free_count[sel_idx] <= free_rel;
        use_count[sel_idx]  <= use_rel;
      end
    end
  end

  // working registers and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= opcode;
      cnt_q     <= count;
      sel_q     <= cpu_select;
      base_q    <= base_vector;
      sel_idx   <= (opcode == bvra_pkg::OP_FREE) ? bvra_pkg::CPU_W'(cpu_select) : '0;
      best_cpu  <= '0;
      best_free <= '0;
    end
    if (cmd.scan_step) begin
      if (free_cur > best_free) begin
        best_free <= free_cur;
        best_cpu  <= sel_idx;
      end
      sel_idx <= sel_idx + bvra_pkg::CPU_W'(1);
    end
    if (cmd.pick) begin
      sel_idx <= best_cpu;
      vec_idx <= '0;
      run     <= '0;
    end
    if (cmd.search_step) begin
      vec_idx <= vec_idx + bvra_pkg::VEC_W'(1);
      run     <= map_bit ? '0 : run_inc;
      if (hit) begin
        start_q <= bvra_pkg::VEC_W'(bvra_pkg::SUM_W'(vec_idx) + bvra_pkg::SUM_W'(1)
                                    - bvra_pkg::SUM_W'(cnt_q));
      end
    end
    if (cmd.res_deny) begin
      ok           <= 1'b0;
      chosen_cpu   <= '0;
      first_vector <= '0;
    end
    if (cmd.res_free) begin
      ok           <= 1'b1;
      chosen_cpu   <= '0;
      first_vector <= '0;
    end
    if (cmd.res_alloc) begin
      ok           <= 1'b1;
      chosen_cpu   <= bvra_pkg::CPU_OUT_W'(sel_idx);
      first_vector <= bvra_pkg::FV_W'(start_q);
    end
  end

endmodule

// File: rtl/balanced_vector_range_allocator.sv
// ============================================================================
// balanced_vector_range_allocator: per-CPU contiguous vector range allocator
// Balanced CPU choice plus first-fit run search over a per-CPU used map.
// ============================================================================
// A request word (opcode, count, cpu_select, base_vector) is taken on a clock
// edge with start high and busy low; busy then stays high until the result.
// Each request yields exactly one result word, shown for one cycle with done
// high. The receiver cannot stall: sample ok/chosen_cpu/first_vector when
// done is high. An allocate scans the CPU free counts, then fails on the
// free count or runs a first-fit search that ends at the run found or
// fails when it finds no run: the first-fit search tests one map bit per
// cycle and the CPU pick reads one free count per cycle. A failed allocate
// returns ok=0 with zero fields; a free returns ok=1 with zero fields.
// The maps clear and the free counts fill on reset; no clearing pass.
//
// Structure:
//   bvra_ctrl - sequencer: idle, CPU scan, pick, search, commit
//   bvra_dp   - used maps, free/use counts, search run counter, result word
module balanced_vector_range_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           opcode,
  input  logic [bvra_pkg::REQ_W-1:0]     count,
  input  logic [2:0]                     cpu_select,
  input  logic [bvra_pkg::BASE_W-1:0]    base_vector,
  output logic                           ok,
  output logic [bvra_pkg::CPU_OUT_W-1:0] chosen_cpu,
  output logic [bvra_pkg::FV_W-1:0]      first_vector
);

  bvra_pkg::cmd_t    cmd;   // sequencer commands
  bvra_pkg::status_t stat;  // datapath flags back to the sequencer

  bvra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bvra_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .count        (count),
    .cpu_select   (cpu_select),
    .base_vector  (base_vector),
    .ok           (ok),
    .chosen_cpu   (chosen_cpu),
    .first_vector (first_vector)
  );

endmodule

// File: rtl/bvra_checker.sv
// ============================================================================
// bvra_checker: port-level checks for the allocator
// Result strobe timing and failed-result field values.
// ============================================================================
module bvra_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic                           ok,
  input logic [bvra_pkg::CPU_OUT_W-1:0] chosen_cpu,
  input logic [bvra_pkg::FV_W-1:0]      first_vector
);

  // accepted request raises busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after an accepted request");

  // result only closes out an accepted request
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a request in flight");

  // block is back to idle when the result shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while result is shown");

  // strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held past one cycle");

  // failed word carries zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (chosen_cpu == '0) && (first_vector == '0))
    else $error("failed result with nonzero fields");

endmodule

bind balanced_vector_range_allocator bvra_checker u_bvra_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .ok           (ok),
  .chosen_cpu   (chosen_cpu),
  .first_vector (first_vector)
);
